/* rtl/ret_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ret_pkg: shared types for the event object table
// Opcodes, status codes and the command token that walks the cell chain.
// ----------------------------------------------------------------------------
package ret_pkg;

  localparam int unsigned PID_W = 8;
  localparam int unsigned SIG_W = 8;
  localparam logic [SIG_W-1:0] SIG_SAT = '1;

  // configuration register byte addresses
  localparam logic [1:0] ADDR_MAX_SIG = 2'd0;

  // command opcodes
  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_CREATE = 2'd1,
    OP_WAIT   = 2'd2,
    OP_SIGNAL = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_OWNED     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // command token, fixed-width part
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [PID_W-1:0] pid;
    logic             done;
    status_e          status;
    logic             blocks;
    logic             wake;
    logic [PID_W-1:0] wpid;
    logic             sw;
  } tok_t;

endpackage

/* rtl/ret_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ret_cell: one table entry of the event object chain
// Holds one slot, acts on the command token passing by and hands it on.
// ----------------------------------------------------------------------------
module ret_cell #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         clear_i,
  input  logic [ret_pkg::SIG_W-1:0]    max_sig_i,
  input  ret_pkg::tok_t                tok_i,
  input  logic [ID_BITS-1:0]           eid_i,
  input  logic [ID_BITS-1:0]           nid_i,
  output ret_pkg::tok_t                tok_o,
  output logic [ID_BITS-1:0]           eid_o,
  output logic [ID_BITS-1:0]           nid_o
);
  import ret_pkg::*;

  logic             valid_q, valid_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [PID_W-1:0] owner_q, owner_d;
  logic [SIG_W-1:0] sig_q, sig_d;
  tok_t             tok_q, tok_d;
  logic [ID_BITS-1:0] eid_q, nid_q;
  logic             hit;
  logic             sig_room;

  assign hit = valid_q && (id_q == eid_i) && (eid_i != '0);
  assign sig_room = (max_sig_i == '0) ? (sig_q != SIG_SAT) : (sig_q < max_sig_i);

  // slot update and token handling
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    owner_d = owner_q;
    sig_d   = sig_q;
    tok_d   = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      case (tok_i.op)
        OP_CREATE: begin
          if (!valid_q) begin
            valid_d    = 1'b1;
            id_d       = nid_i;
            owner_d    = '0;
            sig_d      = '0;
            tok_d.done = 1'b1;
          end
        end
        OP_WAIT: begin
          if (hit) begin
            tok_d.done = 1'b1;
            if (owner_q != '0 && owner_q != tok_i.pid) begin
              tok_d.status = ST_OWNED;
            end else if (sig_q != '0) begin
              valid_d = 1'b0;
            end else begin
              owner_d      = tok_i.pid;
              tok_d.blocks = 1'b1;
              tok_d.sw     = 1'b1;
            end
          end
        end
        OP_SIGNAL: begin
          if (hit) begin
            tok_d.done = 1'b1;
            if (sig_room) begin
              sig_d = sig_q + 1'b1;
            end
            if (owner_q != '0) begin
              tok_d.wake = 1'b1;
              tok_d.wpid = owner_q;
              tok_d.sw   = 1'b1;
              valid_d    = 1'b0;
            end
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (en_i) begin
      valid_q <= clear_i ? 1'b0 : valid_d;
      tok_q   <= tok_d;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end
  end

  // slot payload and token payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      id_q    <= id_d;
      owner_q <= owner_d;
      sig_q   <= sig_d;
      eid_q   <= eid_i;
      nid_q   <= nid_i;
    end
  end

  assign tok_o = tok_q;
  assign eid_o = eid_q;
  assign nid_o = nid_q;

endmodule

/* rtl/rtos_event_table_top.sv */
`timescale 1ns / 1ps
// The command token passes through the register of each table cell in order,
// one table cell per cycle, then into the result register; it waits in the
// last cell while that register cannot take it. One command is in flight.
// Reset: rst_ni clears the table, the last issued ID and max_signal_count;
// an opcode 0 command clears the table in the cycle it is accepted.
// ----------------------------------------------------------------------------
// rtos_event_table_top: hardware table of kernel event objects
// Create, wait and signal commands resolved by a chain of slot cells.
// ----------------------------------------------------------------------------
module rtos_event_table_top #(
  parameter int unsigned MAX_EVENTS = 16,
  parameter int unsigned ID_BITS    = 16,
  localparam int unsigned IN_W  = ((2 + ID_BITS + ret_pkg::PID_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 + ID_BITS + 3 + ret_pkg::PID_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave side
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: opcode, event_id, caller_pid (lowest first), zero padded
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // master side
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // tdata: status, created_id, caller_blocks, wake_valid, wake_pid,
  // switch_request (lowest first), zero padded
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // configuration port
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [1:0]       paddr_i,
  input  logic [31:0]      pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  import ret_pkg::*;

  localparam int unsigned RES_W = 3 + ID_BITS + 3 + PID_W;

  logic [SIG_W-1:0]   max_sig_q;
  logic [ID_BITS-1:0] last_id_q;
  logic               busy_q;
  logic               out_valid_q;
  logic [RES_W-1:0]   out_data_q;

  tok_t               tok   [MAX_EVENTS+1];
  logic [ID_BITS-1:0] eid   [MAX_EVENTS+1];
  logic [ID_BITS-1:0] nid   [MAX_EVENTS+1];

  logic               in_xfer;
  logic               cfg_wr;
  logic               en;
  logic               take;
  logic [ID_BITS-1:0] nid_inc;
  tok_t               tail;
  status_e            res_status;
  logic [ID_BITS-1:0] res_created;

  // configuration register
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign prdata_o = {{(32-SIG_W){1'b0}}, max_sig_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sig_q <= '0;
    end else if (cfg_wr && paddr_i == ADDR_MAX_SIG) begin
      max_sig_q <= pwdata_i[SIG_W-1:0];
    end
  end

  // input token
  assign s_axis_tready_o = !busy_q;
  assign in_xfer = s_axis_tvalid_i && !busy_q;
  assign nid_inc = last_id_q + 1'b1;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = in_xfer;
    tok[0].op     = op_e'(s_axis_tdata_i[1:0]);
    tok[0].pid    = s_axis_tdata_i[ID_BITS+2 +: PID_W];
    tok[0].status = ST_OK;
    eid[0]        = s_axis_tdata_i[2 +: ID_BITS];
    nid[0]        = (nid_inc == '0) ? {{(ID_BITS-1){1'b0}}, 1'b1} : nid_inc;
  end

  // chain stalls only when the tail token cannot leave
  assign tail = tok[MAX_EVENTS];
  assign take = tail.valid && (!out_valid_q || m_axis_tready_i);
  assign en   = !(tail.valid && !take);

  // cell chain
  for (genvar k = 0; k < MAX_EVENTS; k++) begin : g_cell
    ret_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .clear_i   (in_xfer && tok[0].op == OP_RESET),
      .max_sig_i (max_sig_q),
      .tok_i     (tok[k]),
      .eid_i     (eid[k]),
      .nid_i     (nid[k]),
      .tok_o     (tok[k+1]),
      .eid_o     (eid[k+1]),
      .nid_o     (nid[k+1])
    );
  end

  // final status of the command leaving the chain
  always_comb begin
    res_status  = tail.status;
    res_created = '0;
    if (!tail.done) begin
      case (tail.op)
        OP_CREATE: res_status = ST_FULL;
        OP_WAIT,
        OP_SIGNAL: res_status = (eid[MAX_EVENTS] == '0) ? ST_INVALID : ST_NOT_FOUND;
        default:   res_status = ST_OK;
      endcase
    end else if (tail.op == OP_CREATE) begin
      res_created = nid[MAX_EVENTS];
    end
  end

  // busy flag, issued ID and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      last_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (in_xfer && tok[0].op == OP_RESET) begin
        last_id_q <= '0;
      end else if (take && tail.op == OP_CREATE && tail.done) begin
        last_id_q <= nid[MAX_EVENTS];
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= {tail.sw, tail.wpid, tail.wake, tail.blocks, res_created, res_status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W-RES_W){1'b0}}, out_data_q};

endmodule
